// File: sv/sca_pkg.sv
// Shared types and constants for the size-class bump allocator.
package sca_pkg;

  localparam int REQ_W        = 16;
  localparam int SEGMENT_LOG2 = 17;
  localparam int COUNTER_BITS = 20;
  localparam int MIN_CLASS    = 2;
  localparam int MAX_CLASS    = 11;
  localparam int CLASS_COUNT  = MAX_CLASS - MIN_CLASS + 1;

  localparam int LOG_W    = $clog2(REQ_W);
  localparam int IDX_W    = $clog2(CLASS_COUNT);
  localparam int SHAMT_W  = $clog2(MAX_CLASS + 2);
  localparam int ADDR_W   = COUNTER_BITS + MAX_CLASS + 1;
  localparam int STATUS_W = 2;
  localparam int CLS_W    = 4;
  localparam int SEG_W    = 15;
  localparam int OFF_W    = 17;

  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_TOO_LARGE = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EXHAUSTED = 2'd2;

  typedef struct packed {
    logic               err;
    logic [IDX_W-1:0]   idx;
    logic [SHAMT_W-1:0] shamt;
  } sca_cls_t;

endpackage

// File: sv/sca_class_dec.sv
// Size class decode: floor(log2(size)) clamped, range check, slot shift.
module sca_class_dec
  import sca_pkg::*;
(
  input  logic [REQ_W-1:0] request_size,
  output sca_cls_t         cls_o
);

  logic [LOG_W-1:0] lg;
  logic [LOG_W-1:0] cls;

  always_comb begin
    lg = '0;
    for (int i = 1; i < REQ_W; i++) begin
      if (request_size[i]) lg = LOG_W'(i);
    end
    cls = (lg < LOG_W'(MIN_CLASS)) ? LOG_W'(MIN_CLASS) : lg;
    cls_o.err   = (cls > LOG_W'(MAX_CLASS));
    cls_o.idx   = cls_o.err ? '0 : IDX_W'(cls - LOG_W'(MIN_CLASS));
    cls_o.shamt = SHAMT_W'(cls) + SHAMT_W'(1);
  end

endmodule

// File: sv/size_class_bump_allocator_top.sv
// Size-class bump allocator top level: counter memory, forwarding, output register.
// An accepted word is registered with its counter read, then in the output register.
// Throughput: one word per cycle unless out_ready stalls the output; the counter read-modify-write
// is covered by forwarding the value written at the edge where the next read happens.
// Reset clears per-class valid flags, so all counters read as zero; no clearing pass.
module size_class_bump_allocator_top
  import sca_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [REQ_W-1:0]    in_request_size,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [STATUS_W-1:0] out_status,
  output logic [CLS_W-1:0]    out_size_class,
  output logic [SEG_W-1:0]    out_segment_number,
  output logic [OFF_W-1:0]    out_segment_offset,
  output logic                out_opens_segment
);

  localparam logic [COUNTER_BITS-1:0] CNT_FULL = '1;

  logic [COUNTER_BITS-1:0] mem_r [CLASS_COUNT];
  logic [CLASS_COUNT-1:0]  ent_vld_r;

  sca_cls_t                in_cls;
  sca_cls_t                s1_cls_r;
  logic                    s1_vld_r;
  logic [COUNTER_BITS-1:0] rd_data_r;
  logic                    rd_vld_r;
  logic                    fwd_vld_r;
  logic [COUNTER_BITS-1:0] fwd_val_r;

  logic                    out_valid_r;
  logic [STATUS_W-1:0]     status_r;
  logic [CLS_W-1:0]        size_class_r;
  logic [SEG_W-1:0]        seg_r;
  logic [OFF_W-1:0]        off_r;
  logic                    opens_r;

  logic                    adv;
  logic                    load;
  logic [COUNTER_BITS-1:0] cnt;
  logic [COUNTER_BITS-1:0] cnt_inc;
  logic                    full;
  logic                    wr_en;
  logic [ADDR_W-1:0]       addr;
  logic [SEG_W-1:0]        seg;
  logic [OFF_W-1:0]        off;

  sca_class_dec u_dec (
    .request_size (in_request_size),
    .cls_o        (in_cls)
  );

  assign adv      = !out_valid_r || out_ready;
  assign in_ready = !s1_vld_r || adv;
  assign load     = in_valid && in_ready;

  assign cnt     = fwd_vld_r ? fwd_val_r : (rd_vld_r ? rd_data_r : '0);
  assign cnt_inc = cnt + COUNTER_BITS'(1);
  assign full    = (cnt == CNT_FULL);
  assign wr_en   = adv && s1_vld_r && !s1_cls_r.err && !full;
  assign addr    = ADDR_W'(cnt) << s1_cls_r.shamt;
  assign seg     = addr[SEGMENT_LOG2 +: SEG_W];
  assign off     = addr[OFF_W-1:0];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[s1_cls_r.idx] <= cnt_inc;
    end
    if (load) begin
      rd_data_r <= mem_r[in_cls.idx];
      s1_cls_r  <= in_cls;
      fwd_val_r <= cnt_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_vld_r <= '0;
      s1_vld_r  <= 1'b0;
      rd_vld_r  <= 1'b0;
      fwd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        ent_vld_r[s1_cls_r.idx] <= 1'b1;
      end
      if (load) begin
        s1_vld_r  <= 1'b1;
        rd_vld_r  <= ent_vld_r[in_cls.idx];
        fwd_vld_r <= wr_en && (s1_cls_r.idx == in_cls.idx);
      end else if (adv) begin
        s1_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_vld_r) begin
      if (s1_cls_r.err) begin
        status_r     <= STATUS_TOO_LARGE;
        size_class_r <= '0;
        seg_r        <= '0;
        off_r        <= '0;
        opens_r      <= 1'b0;
      end else if (full) begin
        status_r     <= STATUS_EXHAUSTED;
        size_class_r <= CLS_W'(s1_cls_r.idx);
        seg_r        <= '0;
        off_r        <= '0;
        opens_r      <= 1'b0;
      end else begin
        status_r     <= STATUS_OK;
        size_class_r <= CLS_W'(s1_cls_r.idx);
        seg_r        <= seg;
        off_r        <= off;
        opens_r      <= (off == '0) && (seg != '0);
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = status_r;
  assign out_size_class     = size_class_r;
  assign out_segment_number = seg_r;
  assign out_segment_offset = off_r;
  assign out_opens_segment  = opens_r;

endmodule
